// ===== rtl/mm4_pkg.sv =====
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

  // Default matrix dimension.
  localparam int DIM_DEFAULT = 4;

  // Element width and fraction width of the Q16.16 format.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  // Saturation bounds of the result.
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // One input beat: an element of each matrix at the same position.
  typedef struct packed {
    logic signed [DATA_W-1:0] left_elem;
    logic signed [DATA_W-1:0] right_elem;
  } mm4_item_t;

  // One result beat: a product element and the final-element mark.
  typedef struct packed {
    logic signed [DATA_W-1:0] prod_elem;
    logic                     last_elem;
  } mm4_result_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic wr_en;      // store the current input beat
    logic issue;      // read one operand pair and multiply it
    logic first_k;    // first term of a dot product
    logic last_k;     // last term of a dot product
    logic last_elem;  // term belongs to the final product element
  } mm4_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;       // the final product element is on the result port
  } mm4_status_t;

endpackage

// ===== rtl/mm4_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mm4_ctrl.sv =====
// Controller: load counting and the multiply-accumulate sequence.
module mm4_ctrl import mm4_pkg::*; #(
  parameter int DIM = DIM_DEFAULT,
  localparam int ELEMS = DIM * DIM,
  localparam int ADDR_W = $clog2(ELEMS),
  localparam int IDX_W = $clog2(DIM)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output mm4_cmd_t          cmd_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [ADDR_W-1:0] laddr_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  mm4_status_t       status_i
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ELEMS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DIM - 1);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_CALC  = 3'b010,
    ST_DRAIN = 3'b100
  } mm4_state_e;

  mm4_state_e        state_q, state_d;
  logic [ADDR_W-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  col_q, col_d;
  logic [IDX_W-1:0]  k_q, k_d;

  assign busy = (state_q != ST_LOAD);

  // Next-state logic and command decode.
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    k_d        = k_q;
    cmd_o      = '0;
    case (state_q)
      ST_LOAD: begin
        if (start) begin
          cmd_o.wr_en = 1'b1;
          if (load_cnt_q == LAST_ADDR) begin
            load_cnt_d = '0;
            state_d    = ST_CALC;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        cmd_o.issue     = 1'b1;
        cmd_o.first_k   = (k_q == '0);
        cmd_o.last_k    = (k_q == LAST_IDX);
        cmd_o.last_elem = (k_q == LAST_IDX) && (row_q == LAST_IDX) && (col_q == LAST_IDX);
        if (k_q == LAST_IDX) begin
          k_d = '0;
          if (row_q == LAST_IDX) begin
            row_d = '0;
            if (col_q == LAST_IDX) begin
              col_d   = '0;
              state_d = ST_DRAIN;
            end else begin
              col_d = col_q + 1'b1;
            end
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status_i.done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Column-major operand addresses: A[row][k] and B[k][col].
  assign waddr_o = load_cnt_q;
  assign laddr_o = ADDR_W'(int'(row_q) + DIM * int'(k_q));
  assign raddr_o = ADDR_W'(int'(k_q) + DIM * int'(col_q));

  // State and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      k_q        <= k_d;
    end
  end

endmodule

// ===== rtl/mm4_dpath.sv =====
// Datapath: operand stores, multiplier, accumulator and saturating output.
module mm4_dpath import mm4_pkg::*; #(
  parameter int DIM = DIM_DEFAULT,
  localparam int ELEMS = DIM * DIM,
  localparam int ADDR_W = $clog2(ELEMS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mm4_item_t         item_i,
  input  mm4_cmd_t          cmd_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [ADDR_W-1:0] laddr_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output mm4_status_t       status_o,
  output logic              result_valid_o,
  output mm4_result_t       result_o
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(DIM);
  localparam int TOP_B  = FRAC_W + DATA_W - 1;

  logic signed [DATA_W-1:0] left_rd, right_rd;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_d, acc_q;
  logic signed [DATA_W-1:0] sat_val;
  logic [ACC_W-1:TOP_B]     acc_top;
  mm4_cmd_t                 s1_q, s2_q, s3_q;
  mm4_result_t              result_q;
  logic                     result_valid_q;

  // Operand stores for the left and right matrices.
  mm4_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr_i),
    .wdata_i (item_i.left_elem),
    .raddr_i (laddr_i),
    .rdata_o (left_rd)
  );

  mm4_ram #(.WIDTH(DATA_W), .DEPTH(ELEMS)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr_i),
    .wdata_i (item_i.right_elem),
    .raddr_i (raddr_i),
    .rdata_o (right_rd)
  );

  // Full-precision signed product and running dot-product sum.
  assign prod_d = left_rd * right_rd;
  assign acc_d  = (s2_q.first_k ? '0 : acc_q) + ACC_W'(prod_q);

  // Floor shift by the fraction width, then clamp to the 32-bit range.
  assign acc_top = acc_q[ACC_W-1:TOP_B];
  always_comb begin
    if ((&acc_top) || !(|acc_top)) begin
      sat_val = acc_q[TOP_B:FRAC_W];
    end else if (acc_q[ACC_W-1]) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = SAT_MAX;
    end
  end

  // Command flags follow the data down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q           <= '0;
      s2_q           <= '0;
      s3_q           <= '0;
      result_valid_q <= 1'b0;
    end else begin
      s1_q           <= cmd_i;
      s2_q           <= s1_q;
      s3_q           <= s2_q;
      result_valid_q <= s3_q.issue && s3_q.last_k;
    end
  end

  // Product, accumulator and output registers.
  always_ff @(posedge clk_i) begin
    if (s1_q.issue) begin
      prod_q <= prod_d;
    end
    if (s2_q.issue) begin
      acc_q <= acc_d;
    end
    if (s3_q.issue && s3_q.last_k) begin
      result_q.prod_elem <= sat_val;
      result_q.last_elem <= s3_q.last_elem;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;
  assign status_o.done  = result_valid_q && result_q.last_elem;

endmodule

// ===== rtl/matrix4_multiply_top.sv =====
// Top level of the DIM x DIM signed Q16.16 matrix multiplier.
//
// A beat on item_i is taken at each rising edge where start is high and busy is
// low; DIM*DIM beats load one matrix pair in column-major order, one element of
// each matrix per beat. After the final load beat busy rises and the block works
// through the product with one shared 32x32 multiplier, one product term per
// cycle. Results come out in column-major order, each on result_o for a single
// cycle marked by result_valid_o; the final one carries last_elem. The receiver
// cannot stall, so it must take every result as it appears. busy falls in the
// cycle after the final result.
module matrix4_multiply_top import mm4_pkg::*; #(
  parameter int DIM = DIM_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  mm4_item_t   item_i,
  output logic        result_valid_o,
  output mm4_result_t result_o
);

  localparam int ADDR_W = $clog2(DIM * DIM);

  mm4_cmd_t          cmd;
  mm4_status_t       status;
  logic [ADDR_W-1:0] waddr, laddr, raddr;

  // Sequencer for loading and the multiply-accumulate passes.
  mm4_ctrl #(.DIM(DIM)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .waddr_o  (waddr),
    .laddr_o  (laddr),
    .raddr_o  (raddr),
    .status_i (status)
  );

  // Stores, arithmetic and result register.
  mm4_dpath #(.DIM(DIM)) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .waddr_i        (waddr),
    .laddr_i        (laddr),
    .raddr_i        (raddr),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
